// ===== sv/loop_patch_point_gather_macros.svh =====
// Assertion helpers for the file that checks this block.
`ifndef LOOP_PATCH_POINT_GATHER_MACROS_SVH
`define LOOP_PATCH_POINT_GATHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lppg_pkg.sv =====
package lppg_pkg;

   localparam int VTX_W = 12;
   localparam int SLOT_IN_W = 4;
   localparam int VAL_W = 5;
   localparam int POS_W = 5;
   // Ring offsets stay below the 5-bit valence, counters below 64.
   localparam int A_W = 5;
   localparam int CNT_W = 6;
   localparam int K_W = 6;

   localparam int CMD_Q_DEPTH = 4;
   localparam int RSP_Q_DEPTH = 4;

   localparam logic [VAL_W-1:0] REG_VALENCE = 5'd6;
   localparam logic [K_W-1:0] REG_POINTS = 6'd12;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [VTX_W-1:0] vtx_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_NOT_NB,
      STATUS_VAL_BIG
   } status_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_QUERY,
      CMD_ERR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      status_type err;
      vtx_type v0;
      vtx_type v1;
      vtx_type v2;
      logic [SLOT_IN_W-1:0] slot;
      logic [VAL_W-1:0] valence;
      logic ring_wr;
   } cmd_type;

   typedef struct packed {
      vtx_type point_index;
      logic [POS_W-1:0] point_position;
      logic irregular_patch;
      status_type status;
      logic last;
   } res_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_VAL,
      BK_PICK,
      BK_SCAN,
      BK_EMIT_RD,
      BK_EMIT_WR,
      BK_ERR
   } bk_state_type;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RES_W = $bits(res_type);

   // x mod 6 for x below 64, by reciprocal multiply (43/256).
   function automatic logic [2:0] mod6(input logic [5:0] x);
      logic [11:0] prod;
      logic [5:0] q;
      logic [5:0] r;
      prod = 12'(x) * 12'd43;
      q = {2'b00, prod[11:8]};
      r = x - 6'(q * 6'd6);
      return r[2:0];
   endfunction

endpackage

// ===== sv/lppg_ram.sv =====
module lppg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lppg_fifo.sv =====
module lppg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== sv/lppg_front.sv =====
module lppg_front #(
   parameter int MAX_VERTICES = 4096,
   parameter int MAX_VALENCE = 16
) (
   input  logic                     req_fire,
   input  logic                     req_op,
   input  logic [11:0]              req_load_vertex,
   input  logic [3:0]               req_load_slot,
   input  logic [11:0]              req_load_neighbour,
   input  logic [4:0]               req_load_valence,
   input  logic [11:0]              req_face_vertex_a,
   input  logic [11:0]              req_face_vertex_b,
   input  logic [11:0]              req_face_vertex_c,
   output logic                     cmd_push,
   output lppg_pkg::cmd_type        cmd
);
   import lppg_pkg::*;

   logic val_big, load_out, face_out, drop;

   assign val_big = int'(req_load_valence) > MAX_VALENCE;
   assign load_out = int'(req_load_vertex) >= MAX_VERTICES;
   assign face_out = (int'(req_face_vertex_a) >= MAX_VERTICES) ||
                     (int'(req_face_vertex_b) >= MAX_VERTICES) ||
                     (int'(req_face_vertex_c) >= MAX_VERTICES);

   always_comb begin
      cmd = '0;
      drop = 1'b0;
      cmd.slot = req_load_slot;
      cmd.valence = req_load_valence;
      cmd.ring_wr = int'(req_load_slot) < MAX_VALENCE;
      cmd.err = STATUS_OK;
      if (req_op == OP_LOAD) begin
         cmd.v0 = req_load_vertex;
         cmd.v1 = req_load_neighbour;
         cmd.v2 = '0;
         priority if (val_big) begin
            cmd.kind = CMD_ERR;
            cmd.err = STATUS_VAL_BIG;
         end else if (load_out) begin
            cmd.kind = CMD_LOAD;
            drop = 1'b1;
         end else begin
            cmd.kind = CMD_LOAD;
         end
      end else begin
         cmd.v0 = req_face_vertex_a;
         cmd.v1 = req_face_vertex_b;
         cmd.v2 = req_face_vertex_c;
         if (face_out) begin
            cmd.kind = CMD_ERR;
            cmd.err = STATUS_NOT_NB;
         end else begin
            cmd.kind = CMD_QUERY;
         end
      end
   end

   assign cmd_push = req_fire && !drop;

endmodule

// ===== sv/lppg_back.sv =====
module lppg_back #(
   parameter int MAX_VERTICES = 4096,
   parameter int MAX_VALENCE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lppg_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              res_full,
   output logic              res_push,
   output lppg_pkg::res_type res
);
   import lppg_pkg::*;

   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int SW = $clog2(MAX_VALENCE);
   localparam int RAW = VAW + SW;
   localparam int RING_DEPTH = MAX_VERTICES * (2 ** SW);

   bk_state_type state_ff, state_in;
   status_type err_ff;
   vtx_type f_ff [3];
   logic [VAL_W-1:0] val_ff [3];
   logic [A_W-1:0] a_ff [3];
   logic irr_ff;
   logic [CNT_W-1:0] cnt_ff;
   vtx_type prev_ff;
   logic [1:0] ph_ff;
   logic [K_W-1:0] k_ff;
   logic emit_dir_ff;
   vtx_type emit_val_ff;

   // Memory ports.
   logic val_wr_en, val_rd_en, ring_wr_en, ring_rd_en;
   logic [VAW-1:0] val_rd_addr;
   logic [RAW-1:0] ring_wr_addr, ring_rd_addr;
   logic [VAL_W-1:0] val_rd_data;
   vtx_type ring_rd_data;

   // Scan unit.
   vtx_type scan_v, scan_x, scan_y, val_rd_v;
   logic [VAL_W-1:0] scan_n;
   logic [A_W-1:0] n_m1, hit_i, adj_meet;
   logic hit, fail;

   // Emission source.
   logic [VAL_W-1:0] n0;
   logic [K_W-1:0] total, k_off;
   logic is_last;
   logic em_dir;
   vtx_type em_dval, em_vtx;
   logic [SW-1:0] em_slot;
   logic [6:0] irr_s;

   lppg_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (VAW'(cmd.v0)),
      .wr_data (cmd.valence),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   lppg_ram #(.WIDTH(VTX_W), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (cmd.v1),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // Which ring is scanned in each phase, and what it looks for.
   always_comb begin
      unique case (ph_ff)
         2'd0: begin
            scan_v = f_ff[0]; scan_n = val_ff[0]; scan_x = f_ff[1]; scan_y = f_ff[2];
         end
         2'd1: begin
            scan_v = f_ff[1]; scan_n = val_ff[1]; scan_x = f_ff[0]; scan_y = f_ff[2];
         end
         default: begin
            scan_v = f_ff[2]; scan_n = val_ff[2]; scan_x = f_ff[0]; scan_y = f_ff[1];
         end
      endcase
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: val_rd_v = f_ff[0];
         2'd1: val_rd_v = f_ff[1];
         default: val_rd_v = f_ff[2];
      endcase
   end

   assign hit = (cnt_ff >= CNT_W'(2)) && ((prev_ff == scan_x) || (prev_ff == scan_y));
   assign fail = !hit && (CNT_W'(scan_n) <= cnt_ff);
   assign hit_i = A_W'(cnt_ff - CNT_W'(2));
   assign n_m1 = scan_n - 1'b1;
   assign adj_meet = ((ring_rd_data != scan_x) && (ring_rd_data != scan_y)) ? n_m1 : hit_i;

   // Control point source for position k.
   assign n0 = val_ff[0];
   assign total = irr_ff ? K_W'(n0) + K_W'(6) : REG_POINTS;
   assign is_last = (k_ff == total - 1'b1);
   assign k_off = k_ff - K_W'(n0) - 1'b1;
   always_comb begin
      irr_s = 7'(a_ff[0]) + 7'(n0) + 7'd1 - 7'(k_ff);
      if (irr_s >= 7'(n0)) begin
         irr_s = irr_s - 7'(n0);
      end
   end

   always_comb begin
      em_dir = 1'b0;
      em_dval = f_ff[0];
      em_vtx = f_ff[0];
      em_slot = '0;
      if (!irr_ff) begin
         unique case (k_ff)
            6'd0: em_slot = SW'(mod6(6'(a_ff[0]) + 6'd4));
            6'd1: em_slot = SW'(mod6(6'(a_ff[0]) + 6'd3));
            6'd2: em_slot = SW'(mod6(6'(a_ff[0]) + 6'd5));
            6'd3: em_dir = 1'b1;
            6'd4: em_slot = SW'(mod6(6'(a_ff[0]) + 6'd2));
            6'd5: begin
               em_vtx = f_ff[1]; em_slot = SW'(mod6(6'(a_ff[1]) + 6'd3));
            end
            6'd6: begin
               em_dir = 1'b1; em_dval = f_ff[1];
            end
            6'd7: begin
               em_dir = 1'b1; em_dval = f_ff[2];
            end
            6'd8: begin
               em_vtx = f_ff[2]; em_slot = SW'(mod6(6'(a_ff[2]) + 6'd4));
            end
            6'd9: begin
               em_vtx = f_ff[1]; em_slot = SW'(mod6(6'(a_ff[1]) + 6'd4));
            end
            6'd10: begin
               em_vtx = f_ff[2]; em_slot = SW'(mod6(6'(a_ff[2]) + 6'd2));
            end
            default: begin
               em_vtx = f_ff[2]; em_slot = SW'(mod6(6'(a_ff[2]) + 6'd3));
            end
         endcase
      end else begin
         priority if (k_ff == 6'd0) begin
            em_dir = 1'b1;
         end else if (k_ff == 6'd1) begin
            em_dir = 1'b1; em_dval = f_ff[1];
         end else if (k_ff <= K_W'(n0)) begin
            em_slot = SW'(irr_s);
         end else begin
            unique case (k_off)
               6'd0: begin
                  em_vtx = f_ff[2]; em_slot = SW'(mod6(6'(a_ff[2]) + 6'd2));
               end
               6'd1: begin
                  em_vtx = f_ff[1]; em_slot = SW'(mod6(6'(a_ff[1]) + 6'd4));
               end
               6'd2: begin
                  em_vtx = f_ff[1]; em_slot = SW'(mod6(6'(a_ff[1]) + 6'd3));
               end
               6'd3: begin
                  em_vtx = f_ff[2]; em_slot = SW'(mod6(6'(a_ff[2]) + 6'd3));
               end
               default: begin
                  em_vtx = f_ff[2]; em_slot = SW'(mod6(6'(a_ff[2]) + 6'd4));
               end
            endcase
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_QUERY: state_in = BK_VAL;
                  CMD_ERR: state_in = BK_ERR;
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_VAL: if (cnt_ff == CNT_W'(3)) state_in = BK_PICK;
         BK_PICK: state_in = BK_SCAN;
         BK_SCAN: begin
            priority if (hit && (ph_ff == 2'd2)) begin
               state_in = BK_EMIT_RD;
            end else if (fail) begin
               state_in = BK_ERR;
            end else begin
               state_in = BK_SCAN;
            end
         end
         BK_EMIT_RD: state_in = BK_EMIT_WR;
         BK_EMIT_WR: begin
            if (!res_full) begin
               state_in = is_last ? BK_IDLE : BK_EMIT_RD;
            end
         end
         BK_ERR: if (!res_full) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs and memory controls.
   always_comb begin
      cmd_pop = (state_ff == BK_IDLE) && cmd_valid;
      val_wr_en = cmd_pop && (cmd.kind == CMD_LOAD);
      ring_wr_en = val_wr_en && cmd.ring_wr;
      ring_wr_addr = {VAW'(cmd.v0), SW'(cmd.slot)};
      val_rd_en = (state_ff == BK_VAL);
      val_rd_addr = VAW'(val_rd_v);
      ring_rd_en = (state_ff == BK_SCAN) || (state_ff == BK_EMIT_RD);
      ring_rd_addr = (state_ff == BK_SCAN) ? {VAW'(scan_v), SW'(cnt_ff)}
                                           : {VAW'(em_vtx), em_slot};
      res_push = ((state_ff == BK_EMIT_WR) || (state_ff == BK_ERR)) && !res_full;
      res = '0;
      if (state_ff == BK_ERR) begin
         res.status = err_ff;
         res.last = 1'b1;
      end else begin
         res.point_index = emit_dir_ff ? emit_val_ff : ring_rd_data;
         res.point_position = k_ff[POS_W-1:0];
         res.irregular_patch = irr_ff;
         res.status = STATUS_OK;
         res.last = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_pop) begin
               f_ff[0] <= cmd.v0;
               f_ff[1] <= cmd.v1;
               f_ff[2] <= cmd.v2;
               err_ff <= cmd.err;
               cnt_ff <= '0;
            end
         end
         BK_VAL: begin
            unique case (cnt_ff[1:0])
               2'd1: val_ff[0] <= val_rd_data;
               2'd2: val_ff[1] <= val_rd_data;
               2'd3: val_ff[2] <= val_rd_data;
               default: ;
            endcase
            cnt_ff <= cnt_ff + 1'b1;
         end
         BK_PICK: begin
            // The first vertex whose valence is not six moves to the front.
            priority if (val_ff[0] != REG_VALENCE) begin
               irr_ff <= 1'b1;
            end else if (val_ff[1] != REG_VALENCE) begin
               irr_ff <= 1'b1;
               f_ff[0] <= f_ff[1]; f_ff[1] <= f_ff[0];
               val_ff[0] <= val_ff[1]; val_ff[1] <= val_ff[0];
            end else if (val_ff[2] != REG_VALENCE) begin
               irr_ff <= 1'b1;
               f_ff[0] <= f_ff[2]; f_ff[2] <= f_ff[0];
               val_ff[0] <= val_ff[2]; val_ff[2] <= val_ff[0];
            end else begin
               irr_ff <= 1'b0;
            end
            ph_ff <= 2'd0;
            cnt_ff <= '0;
         end
         BK_SCAN: begin
            if (cnt_ff != '0) begin
               prev_ff <= ring_rd_data;
            end
            if (fail) begin
               err_ff <= STATUS_NOT_NB;
            end
            if (hit) begin
               ph_ff <= ph_ff + 1'b1;
               cnt_ff <= '0;
               k_ff <= '0;
               if (ph_ff == 2'd0) begin
                  // Put the face in counter-clockwise order around the front.
                  if (prev_ff == f_ff[1]) begin
                     if (ring_rd_data == f_ff[2]) begin
                        a_ff[0] <= hit_i;
                     end else begin
                        a_ff[0] <= n_m1;
                        f_ff[1] <= f_ff[2]; f_ff[2] <= f_ff[1];
                        val_ff[1] <= val_ff[2]; val_ff[2] <= val_ff[1];
                     end
                  end else begin
                     if (ring_rd_data == f_ff[1]) begin
                        a_ff[0] <= hit_i;
                        f_ff[1] <= f_ff[2]; f_ff[2] <= f_ff[1];
                        val_ff[1] <= val_ff[2]; val_ff[2] <= val_ff[1];
                     end else begin
                        a_ff[0] <= n_m1;
                     end
                  end
               end else if (ph_ff == 2'd1) begin
                  a_ff[1] <= adj_meet;
               end else begin
                  a_ff[2] <= adj_meet;
               end
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         BK_EMIT_RD: begin
            emit_dir_ff <= em_dir;
            emit_val_ff <= em_dval;
         end
         BK_EMIT_WR: begin
            if (!res_full) begin
               k_ff <= k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/loop_patch_point_gather.sv =====
// Loop-subdivision patch control point gather.
// Requests enter through a queue-style port: a request is taken on a rising
// edge where push is high and full is low. A load request writes one ring
// entry and the valence of a vertex; a query request names a triangle and
// returns its control point indices, one result per position, the final one
// marked by rsp_last. Results leave through a queue port: the oldest result
// sits on the rsp_ ports while empty is low and is taken when pop is high.
// A front stage classifies requests into a four-entry command queue; a back
// sequencer walks the adjacency memories. A load is written as its command
// is popped in the idle state. A query reads the three valences, moves the
// first irregular vertex to the front, scans each of the three face rings
// (up to valence + 1 slots each), then emits each point in a read state
// and a write state. Reset clears both queues and the sequencer, but not
// the adjacency memories, which must be loaded before they are queried.
// When the receiver stops popping, the four-entry result queue fills, the
// sequencer waits, the command queue fills and full rises; nothing is dropped.
module loop_patch_point_gather #(
   parameter int MAX_VERTICES = 4096,
   parameter int MAX_VALENCE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [11:0] req_load_vertex,
   input  logic [3:0]  req_load_slot,
   input  logic [11:0] req_load_neighbour,
   input  logic [4:0]  req_load_valence,
   input  logic [11:0] req_face_vertex_a,
   input  logic [11:0] req_face_vertex_b,
   input  logic [11:0] req_face_vertex_c,
   output logic        empty,
   input  logic        pop,
   output logic [11:0] rsp_point_index,
   output logic [4:0]  rsp_point_position,
   output logic        rsp_irregular_patch,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);
   import lppg_pkg::*;

`include "loop_patch_point_gather_macros.svh"

   logic req_fire;
   logic cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_in, cmd_out;
   logic rsp_push, rsp_full;
   res_type rsp_in, rsp_out;

   assign req_fire = push && !full;
   assign full = cmd_full;

   // The front classifies each request and drops loads that write nothing.
   lppg_front #(.MAX_VERTICES(MAX_VERTICES), .MAX_VALENCE(MAX_VALENCE)) u_front (
      .req_fire           (req_fire),
      .req_op             (req_op),
      .req_load_vertex    (req_load_vertex),
      .req_load_slot      (req_load_slot),
      .req_load_neighbour (req_load_neighbour),
      .req_load_valence   (req_load_valence),
      .req_face_vertex_a  (req_face_vertex_a),
      .req_face_vertex_b  (req_face_vertex_b),
      .req_face_vertex_c  (req_face_vertex_c),
      .cmd_push           (cmd_push),
      .cmd                (cmd_in)
   );

   lppg_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_Q_DEPTH)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_in),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_out),
      .empty (cmd_empty)
   );

   // The back executes commands strictly in order, so loads and queries
   // see the adjacency store exactly as the request stream left it.
   lppg_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_VALENCE(MAX_VALENCE)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_out),
      .cmd_pop   (cmd_pop),
      .res_full  (rsp_full),
      .res_push  (rsp_push),
      .res       (rsp_in)
   );

   lppg_fifo #(.WIDTH(RES_W), .DEPTH(RSP_Q_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_out),
      .empty (empty)
   );

   assign rsp_point_index = rsp_out.point_index;
   assign rsp_point_position = rsp_out.point_position;
   assign rsp_irregular_patch = rsp_out.irregular_patch;
   assign rsp_status = rsp_out.status;
   assign rsp_last = rsp_out.last;

   `LPPG_ASSERT_NOW(a_rsp_no_overflow, clock, reset, rsp_push, !rsp_full, "result pushed into full queue")
   `LPPG_ASSERT_NOW(a_err_is_last, clock, reset, rsp_push && (rsp_in.status != STATUS_OK), rsp_in.last, "error result not marked last")
   `LPPG_ASSERT_NOW(a_cmd_no_overflow, clock, reset, cmd_push, !cmd_full, "command pushed into full queue")
   `LPPG_ASSERT_NEXT(a_rsp_stays_empty, clock, reset, empty && !rsp_push, empty, "result appeared without push")

endmodule

// ===== bench/tb_top.sv =====
// Testbench for loop_patch_point_gather.
// Load requests build small adjacency neighborhoods, and query requests then
// ask for the control points of triangles drawn from each neighborhood. A
// predictor in this file keeps its own copy of the ring and valence memories
// and computes, for every accepted request, the results that the block must
// return. The monitor checks each result against the oldest prediction.
module tb_top;
   import lppg_pkg::*;

   localparam int MAX_VERT = 4096;
   localparam int MAX_VAL = 16;

   typedef struct {
      logic        op;
      logic [11:0] load_vertex;
      logic [3:0]  load_slot;
      logic [11:0] load_neighbour;
      logic [4:0]  load_valence;
      logic [11:0] face_a;
      logic [11:0] face_b;
      logic [11:0] face_c;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [11:0] rsp_point_index;
   logic [4:0]  rsp_point_position;
   logic        rsp_irregular_patch;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   request_type drv_req = '{op: OP_LOAD, default: '0};

   // Requests waiting to be offered, and control points still to come back.
   request_type pending_requests[$];
   res_type     expected_points[$];

   // The predictor's own copy of the adjacency memories.
   logic [11:0] ring_mem[0:MAX_VERT*MAX_VAL-1];
   logic [4:0]  valence_mem[0:MAX_VERT-1];

   int  requests_taken = 0;
   int  mismatches = 0;
   int  gap_left = 0;
   int  pop_wait = 0;
   bit  rx_hold = 0;
   bit  req_fire = 0;
   bit  rsp_taken = 0;

   loop_patch_point_gather dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_op(drv_req.op),
      .req_load_vertex(drv_req.load_vertex),
      .req_load_slot(drv_req.load_slot),
      .req_load_neighbour(drv_req.load_neighbour),
      .req_load_valence(drv_req.load_valence),
      .req_face_vertex_a(drv_req.face_a),
      .req_face_vertex_b(drv_req.face_b),
      .req_face_vertex_c(drv_req.face_c),
      .empty(empty), .pop(pop),
      .rsp_point_index(rsp_point_index),
      .rsp_point_position(rsp_point_position),
      .rsp_irregular_patch(rsp_irregular_patch),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Slots beyond the ring store read as zero.
   function automatic logic [11:0] ring_entry(logic [11:0] v, int s);
      logic [3:0] s4;
      s4 = s[3:0];
      if (s >= MAX_VAL) return '0;
      return ring_mem[{v, s4}];
   endfunction

   // Finds the first ring slot of v holding x or y; the meeting slot falls
   // back to the last ring slot when the following entry is off the face.
   function automatic bit ring_meets(logic [11:0] v, logic [11:0] x, logic [11:0] y,
                                     output int adj);
      int n;
      logic [11:0] r, nx;
      n = valence_mem[v];
      adj = 0;
      for (int i = 0; i + 1 < n; i++) begin
         r = ring_entry(v, i);
         if (r == x || r == y) begin
            nx = ring_entry(v, i + 1);
            adj = (nx != x && nx != y) ? n - 1 : i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void add_point(logic [11:0] idx, int pos, bit irr, status_type st,
                                     bit last);
      res_type p;
      p.point_index = idx;
      p.point_position = pos[4:0];
      p.irregular_patch = irr;
      p.status = st;
      p.last = last;
      expected_points.push_back(p);
   endfunction

   // Applies one accepted request to the predicted memories and queues the
   // control points (or the error result) that it must produce.
   function automatic void predict_points(request_type rq);
      logic [11:0] f[3], o[3], pts[MAX_VAL+6], t, r, nx;
      int a[3];
      int n, cnt;
      bit irr, found, ok;
      irr = 0;
      found = 0;
      ok = 0;
      if (rq.op == OP_LOAD) begin
         if (rq.load_valence > MAX_VAL) begin
            add_point('0, 0, 0, STATUS_VAL_BIG, 1);
         end else begin
            valence_mem[rq.load_vertex] = rq.load_valence;
            ring_mem[{rq.load_vertex, rq.load_slot}] = rq.load_neighbour;
         end
         return;
      end
      f[0] = rq.face_a;
      f[1] = rq.face_b;
      f[2] = rq.face_c;
      // The first vertex that is not of regular valence goes to the front.
      for (int i = 0; i < 3; i++) begin
         if (valence_mem[f[i]] != 6) begin
            t = f[0];
            f[0] = f[i];
            f[i] = t;
            irr = 1;
            break;
         end
      end
      // Put the face in counter-clockwise order around the front vertex.
      n = valence_mem[f[0]];
      o[0] = f[0];
      for (int i = 0; i + 1 < n && !found; i++) begin
         r = ring_entry(f[0], i);
         nx = ring_entry(f[0], i + 1);
         if (r == f[1]) begin
            if (nx == f[2]) begin
               o[1] = f[1]; o[2] = f[2]; a[0] = i;
            end else begin
               o[1] = f[2]; o[2] = f[1]; a[0] = n - 1;
            end
            found = 1;
         end else if (r == f[2]) begin
            if (nx == f[1]) begin
               o[1] = f[2]; o[2] = f[1]; a[0] = i;
            end else begin
               o[1] = f[1]; o[2] = f[2]; a[0] = n - 1;
            end
            found = 1;
         end
      end
      if (found) begin
         if (ring_meets(o[1], o[0], o[2], a[1])) begin
            ok = ring_meets(o[2], o[0], o[1], a[2]);
         end
      end
      if (!ok) begin
         add_point('0, 0, 0, STATUS_NOT_NB, 1);
         return;
      end
      if (!irr) begin
         pts[0] = ring_entry(o[0], (a[0] + 4) % 6);
         pts[1] = ring_entry(o[0], (a[0] + 3) % 6);
         pts[2] = ring_entry(o[0], (a[0] + 5) % 6);
         pts[3] = o[0];
         pts[4] = ring_entry(o[0], (a[0] + 2) % 6);
         pts[5] = ring_entry(o[1], (a[1] + 3) % 6);
         pts[6] = o[1];
         pts[7] = o[2];
         pts[8] = ring_entry(o[2], (a[2] + 4) % 6);
         pts[9] = ring_entry(o[1], (a[1] + 4) % 6);
         pts[10] = ring_entry(o[2], (a[2] + 2) % 6);
         pts[11] = ring_entry(o[2], (a[2] + 3) % 6);
         cnt = 12;
      end else begin
         // The side vertices are indexed modulo 6 whatever their valence.
         n = valence_mem[o[0]];
         pts[0] = o[0];
         pts[1] = o[1];
         for (int i = n; i > 1; i--) pts[i] = ring_entry(o[0], (a[0] + n - i + 1) % n);
         pts[n+1] = ring_entry(o[2], (a[2] + 2) % 6);
         pts[n+2] = ring_entry(o[1], (a[1] + 4) % 6);
         pts[n+3] = ring_entry(o[1], (a[1] + 3) % 6);
         pts[n+4] = ring_entry(o[2], (a[2] + 3) % 6);
         pts[n+5] = ring_entry(o[2], (a[2] + 4) % 6);
         cnt = n + 6;
      end
      for (int i = 0; i < cnt; i++) add_point(pts[i], i, irr, STATUS_OK, i + 1 == cnt);
   endfunction

   function automatic request_type random_request();
      request_type rq;
      rq.op = OP_LOAD;
      rq.load_vertex = $urandom_range(0, 4095);
      rq.load_slot = $urandom_range(0, 15);
      rq.load_neighbour = $urandom_range(0, 4095);
      rq.load_valence = $urandom_range(0, 31);
      rq.face_a = $urandom_range(0, 4095);
      rq.face_b = $urandom_range(0, 4095);
      rq.face_c = $urandom_range(0, 4095);
      return rq;
   endfunction

   function automatic void queue_load(logic [11:0] v, int s, logic [11:0] nb, int val);
      request_type rq;
      rq = random_request();
      rq.load_vertex = v;
      rq.load_slot = s[3:0];
      rq.load_neighbour = nb;
      rq.load_valence = val[4:0];
      pending_requests.push_back(rq);
   endfunction

   // An oversized valence writes nothing, so the rest of the fields are free.
   function automatic void queue_big_valence(int val);
      request_type rq;
      rq = random_request();
      rq.load_valence = val[4:0];
      pending_requests.push_back(rq);
   endfunction

   function automatic void queue_query(logic [11:0] a, logic [11:0] b, logic [11:0] c);
      request_type rq;
      rq = random_request();
      rq.op = OP_QUERY;
      rq.face_a = a;
      rq.face_b = b;
      rq.face_c = c;
      pending_requests.push_back(rq);
   endfunction

   // A vertex of valence n is loaded in every slot that a query may read:
   // slots below n for ring scans and slots below 6 for the modulo-6 lookups.
   function automatic void queue_ring(logic [11:0] v, int val, logic [11:0] ring[16]);
      int top;
      top = (val > 6) ? val : 6;
      for (int s = 0; s < top; s++) queue_load(v, s, ring[s], val);
   endfunction

   // One random neighborhood: five distinct vertices whose rings are made
   // mostly of each other, then triangles drawn from them.
   function automatic void queue_neighborhood();
      logic [11:0] pool[5], ring[16];
      int val[5];
      bit clash;
      for (int i = 0; i < 5; i++) begin
         do begin
            pool[i] = $urandom_range(0, 4095);
            clash = 0;
            for (int j = 0; j < i; j++) if (pool[j] == pool[i]) clash = 1;
         end while (clash);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: val[i] = 6;
            6: val[i] = 16;
            default: val[i] = $urandom_range(0, 16);
         endcase
      end
      for (int i = 0; i < 5; i++) begin
         for (int s = 0; s < 16; s++) begin
            if ($urandom_range(0, 9) < 8) ring[s] = pool[(i + $urandom_range(1, 4)) % 5];
            else ring[s] = $urandom_range(0, 4095);
         end
         queue_ring(pool[i], val[i], ring);
         if ($urandom_range(0, 3) == 0) queue_big_valence($urandom_range(17, 31));
      end
      for (int q = 0; q < 8; q++) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_query(pool[$urandom_range(0, 4)], pool[$urandom_range(0, 4)],
                        pool[$urandom_range(0, 4)]);
         end else begin
            int i0, i1, i2;
            i0 = $urandom_range(0, 4);
            i1 = (i0 + $urandom_range(1, 4)) % 5;
            do i2 = $urandom_range(0, 4); while (i2 == i0 || i2 == i1);
            queue_query(pool[i0], pool[i1], pool[i2]);
         end
      end
   endfunction

   // Stretches without any idling on either side.
   function automatic bit steady_phase();
      return (requests_taken / 30) % 3 == 1;
   endfunction

   // Sender: a new request goes out once the previous one was taken, after
   // a random pause.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_fire) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            drv_req <= pending_requests.pop_front();
            push <= 1'b1;
            gap_left <= steady_phase() ? 0 : $urandom_range(0, 4);
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Receiver: pop stays low for a random wait after each result, and for the
   // whole of a long hold-off.
   always @(negedge clock) begin
      if (reset || rx_hold) begin
         pop <= 1'b0;
      end else if (!pop || rsp_taken) begin
         if (pop_wait > 0) begin
            pop_wait <= pop_wait - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            pop_wait <= steady_phase() ? 0 : $urandom_range(0, 4);
         end
      end
   end

   // Monitor: requests are predicted as they are accepted, and results are
   // compared with the oldest prediction as they are popped.
   always @(posedge clock) begin
      res_type exp_pt;
      req_fire <= !reset && push && !full;
      rsp_taken <= !reset && pop && !empty;
      if (!reset && push && !full) begin
         predict_points(drv_req);
         requests_taken <= requests_taken + 1;
      end
      if (!reset && pop && !empty) begin
         if (expected_points.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("Unexpected result: index %0d position %0d status %0d",
                        rsp_point_index, rsp_point_position, rsp_status);
         end else begin
            exp_pt = expected_points.pop_front();
            if (rsp_point_index !== exp_pt.point_index
                || rsp_point_position !== exp_pt.point_position
                || rsp_irregular_patch !== exp_pt.irregular_patch
                || rsp_status !== exp_pt.status
                || rsp_last !== exp_pt.last) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("Mismatch: expected idx %0d pos %0d irr %0d st %0d last %0d, %s",
                           exp_pt.point_index, exp_pt.point_position,
                           exp_pt.irregular_patch, exp_pt.status, exp_pt.last,
                           $sformatf("got idx %0d pos %0d irr %0d st %0d last %0d",
                                     rsp_point_index, rsp_point_position,
                                     rsp_irregular_patch, rsp_status, rsp_last));
            end
         end
      end
   end

   // Long receiver hold-off in the middle of the run, so the result queue
   // fills and the block pushes back on new requests.
   initial begin
      wait (requests_taken >= 40);
      @(posedge clock);
      rx_hold = 1;
      repeat (200) @(posedge clock);
      rx_hold = 0;
   end

   initial begin
      #1600000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [11:0] ring[16];
      for (int i = 0; i < MAX_VERT * MAX_VAL; i++) ring_mem[i] = '0;
      for (int i = 0; i < MAX_VERT; i++) valence_mem[i] = '0;

      // Directed part: oversized valences, then one regular fan around the
      // extreme vertex numbers 0 and 4095, queried in both windings.
      queue_big_valence(17);
      queue_big_valence(31);
      for (int s = 0; s < 16; s++) ring[s] = s[11:0];
      ring[0] = 12'd4095; ring[1] = 12'd5;
      queue_ring(12'd0, 6, ring);
      ring[0] = 12'd5; ring[1] = 12'd0;
      queue_ring(12'd4095, 6, ring);
      ring[0] = 12'd0; ring[1] = 12'd4095;
      queue_ring(12'd5, 6, ring);
      queue_query(12'd0, 12'd4095, 12'd5);
      queue_query(12'd0, 12'd5, 12'd4095);
      queue_query(12'd4095, 12'd5, 12'd0);

      // Random part: neighborhoods until at least 100 requests are queued in all.
      while (pending_requests.size() < 100) queue_neighborhood();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      wait (pending_requests.size() == 0 && !push);
      wait (expected_points.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
